// File: design/zip_stored_stream_checker_defines.svh
// ----------------------------------------------------------------------------
// ZIP stored stream checker assertion macros
// Shared concurrent assertion forms used by the top level.
// ----------------------------------------------------------------------------
`ifndef ZIP_STORED_STREAM_CHECKER_DEFINES_SVH
`define ZIP_STORED_STREAM_CHECKER_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define ZSC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define ZSC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/zsc_pkg.sv
// ----------------------------------------------------------------------------
// ZIP stored stream checker package
// Constants, codes, phase type and CRC-32 byte update.
// ----------------------------------------------------------------------------
`default_nettype none
package zsc_pkg;
    localparam logic [31:0] SIG_LOCAL = 32'h04034B50;
    localparam logic [31:0] SIG_CDIR  = 32'h02014B50;
    localparam logic [31:0] SIG_END   = 32'h06054B50;
    localparam logic [15:0] FLAG_UTF8 = 16'h0800;
    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam int HDR_LEN  = 26;
    localparam int TAIL_LEN = 22;

    localparam logic [31:0] MAX_ENTRY_BYTES_RST = 32'd16777216;
    localparam logic [15:0] MAX_ENTRIES_RST     = 16'd64;
    localparam logic [15:0] NAME_LIMIT_RST      = 16'd160;
    localparam logic [15:0] EXTRA_LIMIT_RST     = 16'd1024;

    typedef enum logic [1:0] {
        MODE_START = 2'd0, MODE_BYTE = 2'd1, MODE_FINISH = 2'd2, MODE_NOP = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_MAX_BYTES = 2'd0, CFG_MAX_ENTRIES = 2'd1,
        CFG_NAME_LIMIT = 2'd2, CFG_EXTRA_LIMIT = 2'd3
    } cfg_idx_t;

    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_NAME  = 2'd1;
    localparam logic [1:0] KIND_DATA  = 2'd2;
    localparam logic [1:0] KIND_TRAIL = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BAD_SIG = 3'd1;
    localparam logic [2:0] ST_BAD_HDR = 3'd2;
    localparam logic [2:0] ST_BAD_CRC = 3'd3;
    localparam logic [2:0] ST_BAD_END = 3'd4;
    localparam logic [2:0] ST_FAILED  = 3'd5;

    typedef enum logic [6:0] {
        PH_SIG   = 7'b0000001,
        PH_HDR   = 7'b0000010,
        PH_NAME  = 7'b0000100,
        PH_EXTRA = 7'b0001000,
        PH_DATA  = 7'b0010000,
        PH_TRAIL = 7'b0100000,
        PH_FAIL  = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  byte_out;
        logic        entry_end;
        logic [15:0] entry_number;
        logic [2:0]  status;
    } result_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction
endpackage
`default_nettype wire

// File: design/zip_stored_stream_checker.sv
// Result: each accepted request's result is registered and appears on the output in the following cycle.
// Throughput: one request per cycle while the output is not stalled; the parser state updates in a single pass.
// Output register with stall: a new request is taken while the held result drains.
// Reset: synchronous active-low; parser enters the failed phase, limits reset.
// ----------------------------------------------------------------------------
// ZIP stored stream checker
// Parses stored-only ZIP archives byte by byte and checks headers, CRC and end record.
// ----------------------------------------------------------------------------
`default_nettype none
`include "zip_stored_stream_checker_defines.svh"
module zip_stored_stream_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_mode,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_kind,
    output logic [7:0]       m_byte_out,
    output logic             m_entry_end,
    output logic [15:0]      m_entry_number,
    output logic [2:0]       m_status,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import zsc_pkg::*;

    logic [31:0] max_bytes_reg;
    logic [15:0] max_ents_reg, name_lim_reg, extra_lim_reg;
    logic        step, valid_reg;
    result_t     res, res_reg;
    phase_t      phase;

    assign s_ready = !valid_reg || m_ready;
    assign step    = s_valid && s_ready;

    zsc_core u_core (
        .aclk(aclk), .aresetn(aresetn), .step(step),
        .mode(s_mode), .data_byte(s_data_byte),
        .max_entry_bytes(max_bytes_reg), .max_entries(max_ents_reg),
        .name_limit(name_lim_reg), .extra_limit(extra_lim_reg),
        .result(res), .phase(phase)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bytes_reg <= MAX_ENTRY_BYTES_RST;
            max_ents_reg  <= MAX_ENTRIES_RST;
            name_lim_reg  <= NAME_LIMIT_RST;
            extra_lim_reg <= EXTRA_LIMIT_RST;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_MAX_BYTES:   max_bytes_reg <= cfg_data;
                CFG_MAX_ENTRIES: max_ents_reg  <= cfg_data[15:0];
                CFG_NAME_LIMIT:  name_lim_reg  <= cfg_data[15:0];
                CFG_EXTRA_LIMIT: extra_lim_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (step) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) res_reg <= res;
    end

    assign m_valid        = valid_reg;
    assign m_kind         = res_reg.kind;
    assign m_byte_out     = res_reg.byte_out;
    assign m_entry_end    = res_reg.entry_end;
    assign m_entry_number = res_reg.entry_number;
    assign m_status       = res_reg.status;

    `ZSC_ASSERT_NEXT(a_start_clean, aclk, aresetn, step && s_mode == MODE_START, m_valid && m_status == ST_OK && m_entry_number == 16'd0)
    `ZSC_ASSERT_NEXT(a_fail_status, aclk, aresetn, step && phase == PH_FAIL && s_mode != MODE_START, m_status == ST_FAILED)
    `ZSC_ASSERT_IMP(a_end_ok, aclk, aresetn, m_valid && m_entry_end, m_status == ST_OK && m_kind != KIND_NAME || m_status == ST_OK)
endmodule
`default_nettype wire

// File: design/zsc_core.sv
// ----------------------------------------------------------------------------
// ZIP stored stream checker core
// Parser state, header capture, CRC check and end record window.
// ----------------------------------------------------------------------------
`default_nettype none
module zsc_core (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step,
    input  wire logic [1:0]       mode,
    input  wire logic [7:0]       data_byte,
    input  wire logic [31:0]      max_entry_bytes,
    input  wire logic [15:0]      max_entries,
    input  wire logic [15:0]      name_limit,
    input  wire logic [15:0]      extra_limit,
    output zsc_pkg::result_t      result,
    output zsc_pkg::phase_t       phase
);
    import zsc_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  hdr_reg [HDR_LEN];
    logic [4:0]  hcnt_reg, hcnt_next;
    logic [7:0]  tail_reg [TAIL_LEN];
    logic [4:0]  tcnt_reg, tcnt_next;
    logic [31:0] boff_reg, boff_next;
    logic [31:0] doff_reg, doff_next;
    logic [31:0] exp_reg, exp_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] dleft_reg, dleft_next;
    logic [15:0] nleft_reg, nleft_next;
    logic [15:0] xleft_reg, xleft_next;
    logic [15:0] ents_reg, ents_next;

    logic        hdr_wr, tail_push, tail_mode;
    logic [4:0]  hdr_idx;
    logic [7:0]  tail_b [4];
    logic [2:0]  tail_n;
    logic [7:0]  tail_new [TAIL_LEN];
    logic [7:0]  hb [HDR_LEN];
    logic [7:0]  seq [TAIL_LEN + 4];
    logic [5:0]  pos;
    logic        do_open, do_close;
    logic [31:0] crc_upd, sig, f_csize, f_dsize;
    logic [15:0] f_flags, f_method, f_name, f_extra;
    logic [32:0] total;
    logic        bad_end;

    assign phase = phase_reg;
    assign crc_upd = crc_byte(crc_reg, data_byte);

    // header view including the byte being written now
    always_comb begin
        for (int i = 0; i < HDR_LEN; i++) begin
            hb[i] = (hdr_wr && hdr_idx == 5'(i)) ? data_byte : hdr_reg[i];
        end
    end
    assign sig      = {hb[3], hb[2], hb[1], hb[0]};
    assign f_flags  = {hb[3], hb[2]};
    assign f_method = {hb[5], hb[4]};
    assign f_csize  = {hb[17], hb[16], hb[15], hb[14]};
    assign f_dsize  = {hb[21], hb[20], hb[19], hb[18]};
    assign f_name   = {hb[23], hb[22]};
    assign f_extra  = {hb[25], hb[24]};

    assign total = 33'({tail_reg[15], tail_reg[14], tail_reg[13], tail_reg[12]})
                 + 33'(doff_reg) + 33'(TAIL_LEN);
    assign bad_end = phase_reg != PH_TRAIL || tcnt_reg != 5'(TAIL_LEN)
        || {tail_reg[3], tail_reg[2], tail_reg[1], tail_reg[0]} != SIG_END
        || {tail_reg[5], tail_reg[4]} != 16'd0 || {tail_reg[7], tail_reg[6]} != 16'd0
        || {tail_reg[9], tail_reg[8]} != ents_reg || {tail_reg[11], tail_reg[10]} != ents_reg
        || {tail_reg[19], tail_reg[18], tail_reg[17], tail_reg[16]} != doff_reg
        || {tail_reg[21], tail_reg[20]} != 16'd0 || total != {1'b0, boff_reg};

    always_comb begin
        phase_next = phase_reg;
        hcnt_next  = hcnt_reg;
        tcnt_next  = tcnt_reg;
        boff_next  = boff_reg;
        doff_next  = doff_reg;
        exp_next   = exp_reg;
        crc_next   = crc_reg;
        dleft_next = dleft_reg;
        nleft_next = nleft_reg;
        xleft_next = xleft_reg;
        ents_next  = ents_reg;
        hdr_wr     = 1'b0;
        hdr_idx    = hcnt_reg;
        tail_push  = 1'b0;
        tail_mode  = 1'b0;
        do_open    = 1'b0;
        do_close   = 1'b0;
        result     = '0;

        case (mode)
            MODE_START: begin
                phase_next = PH_SIG;
                hcnt_next = '0; tcnt_next = '0; boff_next = '0; doff_next = '0;
                exp_next = '0; crc_next = '0; dleft_next = '0; nleft_next = '0;
                xleft_next = '0; ents_next = '0;
            end
            MODE_BYTE: begin
                if (phase_reg == PH_FAIL) begin
                    result.status = ST_FAILED;
                end else begin
                    boff_next = boff_reg + 32'd1;
                    case (phase_reg)
                        PH_SIG: begin
                            hdr_wr = 1'b1;
                            hdr_idx = {3'd0, hcnt_reg[1:0]};
                            hcnt_next = {3'd0, hcnt_reg[1:0]} + 5'd1;
                            if (hcnt_reg[1:0] == 2'd3) begin
                                hcnt_next = '0;
                                if (sig == SIG_LOCAL) begin
                                    phase_next = PH_HDR;
                                end else if (sig == SIG_CDIR) begin
                                    doff_next = boff_next - 32'd4;
                                    phase_next = PH_TRAIL;
                                    tail_push = 1'b1;
                                    tail_mode = 1'b1;
                                end else begin
                                    phase_next = PH_FAIL;
                                    result.status = ST_BAD_SIG;
                                end
                            end
                        end
                        PH_HDR: begin
                            hdr_wr = hcnt_reg < 5'(HDR_LEN);
                            hcnt_next = hdr_wr ? hcnt_reg + 5'd1 : hcnt_reg;
                            if (hcnt_next >= 5'(HDR_LEN)) begin
                                hcnt_next = '0;
                                exp_next = {hb[13], hb[12], hb[11], hb[10]};
                                dleft_next = f_dsize;
                                nleft_next = f_name;
                                xleft_next = f_extra;
                                if ((f_flags & ~FLAG_UTF8) != 16'd0 || f_method != 16'd0
                                    || f_csize != f_dsize || f_dsize > max_entry_bytes
                                    || f_name == 16'd0 || f_name >= name_limit
                                    || f_extra > extra_limit || ents_reg >= max_entries) begin
                                    phase_next = PH_FAIL;
                                    result.status = ST_BAD_HDR;
                                end else begin
                                    phase_next = PH_NAME;
                                end
                            end
                        end
                        PH_NAME: begin
                            result.kind = KIND_NAME;
                            nleft_next = nleft_reg - 16'd1;
                            if (nleft_next == 16'd0) begin
                                if (xleft_reg != 16'd0) phase_next = PH_EXTRA;
                                else do_open = 1'b1;
                            end
                        end
                        PH_EXTRA: begin
                            xleft_next = xleft_reg - 16'd1;
                            if (xleft_next == 16'd0) do_open = 1'b1;
                        end
                        PH_DATA: begin
                            result.kind = KIND_DATA;
                            crc_next = crc_upd;
                            dleft_next = dleft_reg - 32'd1;
                            if (dleft_next == 32'd0) do_close = 1'b1;
                        end
                        default: begin
                            result.kind = KIND_TRAIL;
                            tail_push = 1'b1;
                        end
                    endcase
                    if (do_open) begin
                        crc_next = 32'hFFFFFFFF;
                        phase_next = PH_DATA;
                        if (dleft_reg == 32'd0) do_close = 1'b1;
                    end
                    if (do_close) begin
                        if ((crc_next ^ 32'hFFFFFFFF) != exp_reg) begin
                            phase_next = PH_FAIL;
                            result.status = ST_BAD_CRC;
                        end else begin
                            ents_next = ents_reg + 16'd1;
                            phase_next = PH_SIG;
                            result.entry_end = 1'b1;
                        end
                    end
                end
            end
            MODE_FINISH: begin
                if (phase_reg == PH_FAIL) begin
                    result.status = ST_FAILED;
                end else if (bad_end) begin
                    phase_next = PH_FAIL;
                    result.status = ST_BAD_END;
                end
            end
            default: begin
                if (phase_reg == PH_FAIL) result.status = ST_FAILED;
            end
        endcase
        result.byte_out = (result.kind != KIND_FRAME) ? data_byte : 8'd0;
        result.entry_number = ents_next;
        if (tail_push && mode == MODE_BYTE && phase_reg != PH_FAIL) tcnt_next =
            (5'(tcnt_reg) + 5'(tail_n) > 5'(TAIL_LEN)) ? 5'(TAIL_LEN) : tcnt_reg + 5'(tail_n);
    end

    // window update: append up to four bytes, keep the newest 22
    always_comb begin
        tail_b[0] = tail_mode ? 8'h50 : data_byte;
        tail_b[1] = 8'h4B;
        tail_b[2] = 8'h01;
        tail_b[3] = 8'h02;
        tail_n = tail_mode ? 3'd4 : 3'd1;
        for (int i = 0; i < TAIL_LEN; i++) seq[i] = tail_reg[i];
        for (int i = 0; i < 4; i++) seq[TAIL_LEN + i] = 8'h00;
        for (int i = 0; i < TAIL_LEN + 4; i++) begin
            for (int k = 0; k < 4; k++) begin
                if (k < int'(tail_n) && i == int'(tcnt_reg) + k) seq[i] = tail_b[k];
            end
        end
        pos = 6'(tcnt_reg) + 6'(tail_n);
        for (int i = 0; i < TAIL_LEN; i++) begin
            tail_new[i] = seq[i];
            if (pos > 6'(TAIL_LEN)) begin
                for (int s = 1; s <= 4; s++) begin
                    if (int'(pos) - TAIL_LEN == s) tail_new[i] = seq[i + s];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FAIL;
            hcnt_reg <= '0; tcnt_reg <= '0; boff_reg <= '0; doff_reg <= '0;
            exp_reg <= '0; crc_reg <= '0; dleft_reg <= '0; nleft_reg <= '0;
            xleft_reg <= '0; ents_reg <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            hcnt_reg <= hcnt_next; tcnt_reg <= tcnt_next; boff_reg <= boff_next;
            doff_reg <= doff_next; exp_reg <= exp_next; crc_reg <= crc_next;
            dleft_reg <= dleft_next; nleft_reg <= nleft_next;
            xleft_reg <= xleft_next; ents_reg <= ents_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && mode == MODE_BYTE) begin
            if (hdr_wr) hdr_reg[hdr_idx] <= data_byte;
            if (tail_push && phase_reg != PH_FAIL) begin
                for (int i = 0; i < TAIL_LEN; i++) tail_reg[i] <= tail_new[i];
            end
        end
    end
endmodule
`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ZIP stored stream checker bench
// Feeds generated stored-entry archives, corrupted variants and noise with
// random burst gaps and output stalls, and compares every result against a
// local parser model that tracks limits, CRC and end-record state.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
    import zsc_pkg::*;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data;
    } request_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode = MODE_NOP;
    logic [7:0]  s_data_byte = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [7:0]  m_byte_out;
    logic        m_entry_end;
    logic [15:0] m_entry_number;
    logic [2:0]  m_status;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_MAX_BYTES;
    logic [31:0] cfg_data = 32'd0;

    zip_stored_stream_checker u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode), .s_data_byte(s_data_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind), .m_byte_out(m_byte_out),
        .m_entry_end(m_entry_end), .m_entry_number(m_entry_number), .m_status(m_status),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 aclk = ~aclk;

    // predictor state
    logic [31:0] lim_bytes;
    logic [15:0] lim_entries, lim_name, lim_extra;
    phase_t      ph;
    logic [7:0]  hbuf [HDR_LEN];
    int          hcnt;
    logic [7:0]  twin [TAIL_LEN];
    int          tcnt;
    logic [31:0] boff, doff, crc_want, crc_run, dleft;
    logic [15:0] nleft, xleft, ndone;

    request_t pending_requests[$];
    result_t  expected_results[$];
    int       errors = 0;
    int       burst_left = 0;
    int       gap_left = 0;
    bit       hold_off = 1'b0;
    bit       req_taken = 1'b0;

    function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
        return r;
    endfunction

    function automatic void window_add(logic [7:0] b);
        if (tcnt < TAIL_LEN) begin
            twin[tcnt] = b;
            tcnt++;
        end else begin
            for (int i = 0; i < TAIL_LEN - 1; i++) twin[i] = twin[i + 1];
            twin[TAIL_LEN - 1] = b;
        end
    endfunction

    function automatic void clear_parser(phase_t p);
        ph = p; hcnt = 0; tcnt = 0;
        boff = 0; doff = 0; crc_want = 0; crc_run = 0; dleft = 0;
        nleft = 0; xleft = 0; ndone = 0;
    endfunction

    function automatic logic [2:0] close_entry(ref logic done);
        if ((crc_run ^ 32'hFFFFFFFF) != crc_want) begin
            ph = PH_FAIL;
            return ST_BAD_CRC;
        end
        ndone++; ph = PH_SIG; done = 1'b1;
        return ST_OK;
    endfunction

    function automatic logic [2:0] start_data(ref logic done);
        crc_run = 32'hFFFFFFFF; ph = PH_DATA;
        if (dleft == 0) return close_entry(done);
        return ST_OK;
    endfunction

    function automatic logic [2:0] take_byte(logic [7:0] b, ref logic [1:0] kind,
                                             ref logic done);
        logic [31:0] sig, flags, meth, csize;
        boff++;
        case (ph)
            PH_SIG: begin
                hbuf[hcnt & 3] = b;
                hcnt = (hcnt & 3) + 1;
                if (hcnt != 4) return ST_OK;
                hcnt = 0;
                sig = {hbuf[3], hbuf[2], hbuf[1], hbuf[0]};
                if (sig == SIG_LOCAL) ph = PH_HDR;
                else if (sig == SIG_CDIR) begin
                    doff = boff - 4; ph = PH_TRAIL;
                    window_add(8'h50); window_add(8'h4B); window_add(8'h01); window_add(8'h02);
                end else begin
                    ph = PH_FAIL;
                    return ST_BAD_SIG;
                end
                return ST_OK;
            end
            PH_HDR: begin
                if (hcnt < HDR_LEN) begin
                    hbuf[hcnt] = b;
                    hcnt++;
                end
                if (hcnt < HDR_LEN) return ST_OK;
                flags = {hbuf[3], hbuf[2]};
                meth = {hbuf[5], hbuf[4]};
                csize = {hbuf[17], hbuf[16], hbuf[15], hbuf[14]};
                crc_want = {hbuf[13], hbuf[12], hbuf[11], hbuf[10]};
                dleft = {hbuf[21], hbuf[20], hbuf[19], hbuf[18]};
                nleft = {hbuf[23], hbuf[22]};
                xleft = {hbuf[25], hbuf[24]};
                hcnt = 0;
                if ((flags & ~32'h0800) != 0 || meth != 0 || csize != dleft ||
                    dleft > lim_bytes || nleft == 0 || nleft >= lim_name ||
                    xleft > lim_extra || ndone >= lim_entries) begin
                    ph = PH_FAIL;
                    return ST_BAD_HDR;
                end
                ph = PH_NAME;
                return ST_OK;
            end
            PH_NAME: begin
                kind = KIND_NAME;
                nleft--;
                if (nleft == 0) begin
                    if (xleft != 0) ph = PH_EXTRA;
                    else return start_data(done);
                end
                return ST_OK;
            end
            PH_EXTRA: begin
                xleft--;
                if (xleft == 0) return start_data(done);
                return ST_OK;
            end
            PH_DATA: begin
                kind = KIND_DATA;
                crc_run = crc_step(crc_run, b);
                dleft--;
                if (dleft == 0) return close_entry(done);
                return ST_OK;
            end
            default: begin
                kind = KIND_TRAIL;
                window_add(b);
                return ST_OK;
            end
        endcase
    endfunction

    function automatic logic [2:0] check_end();
        logic [32:0] total;
        if (ph != PH_TRAIL || tcnt != TAIL_LEN) begin
            ph = PH_FAIL;
            return ST_BAD_END;
        end
        total = {1'b0, twin[15], twin[14], twin[13], twin[12]} + {1'b0, doff} + TAIL_LEN;
        if ({twin[3], twin[2], twin[1], twin[0]} != SIG_END ||
            {twin[5], twin[4]} != 0 || {twin[7], twin[6]} != 0 ||
            {twin[9], twin[8]} != ndone || {twin[11], twin[10]} != ndone ||
            {twin[19], twin[18], twin[17], twin[16]} != doff ||
            {twin[21], twin[20]} != 0 || total != {1'b0, boff}) begin
            ph = PH_FAIL;
            return ST_BAD_END;
        end
        return ST_OK;
    endfunction

    function automatic result_t parse_request(request_t r);
        result_t     res;
        logic [1:0]  kind;
        logic        done;
        logic [2:0]  st;
        kind = KIND_FRAME; done = 1'b0; st = ST_OK;
        if (r.mode == MODE_START) clear_parser(PH_SIG);
        else if (ph == PH_FAIL) st = ST_FAILED;
        else if (r.mode == MODE_BYTE) st = take_byte(r.data, kind, done);
        else if (r.mode == MODE_FINISH) st = check_end();
        res.kind = kind;
        res.byte_out = (kind != KIND_FRAME) ? r.data : 8'd0;
        res.entry_end = done;
        res.entry_number = ndone;
        res.status = st;
        return res;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    // driver
    always @(negedge aclk) begin
        if (s_valid && !req_taken) begin
        end else if (hold_off || pending_requests.size() == 0) begin
            s_valid <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left--;
            s_valid <= 1'b0;
        end else begin
            s_valid <= 1'b1;
            s_mode <= pending_requests[0].mode;
            s_data_byte <= pending_requests[0].data;
            void'(pending_requests.pop_front());
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            end else begin
                burst_left--;
            end
        end
        m_ready <= ($urandom_range(0, 7) < ((boff[7]) ? 8 : 5));
    end

    // monitor and predictor
    always @(posedge aclk) begin
        req_taken = s_valid && s_ready && aresetn;
        if (aresetn) begin
            if (s_valid && s_ready)
                expected_results.insert(expected_results.size(),
                                        parse_request('{mode: s_mode, data: s_data_byte}));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report("unexpected result", 0, 0);
                end else begin
                    if (m_kind != expected_results[0].kind)
                        report("kind", m_kind, expected_results[0].kind);
                    if (m_byte_out != expected_results[0].byte_out)
                        report("byte_out", m_byte_out, expected_results[0].byte_out);
                    if (m_entry_end != expected_results[0].entry_end)
                        report("entry_end", m_entry_end, expected_results[0].entry_end);
                    if (m_entry_number != expected_results[0].entry_number)
                        report("entry_number", m_entry_number,
                               expected_results[0].entry_number);
                    if (m_status != expected_results[0].status)
                        report("status", m_status, expected_results[0].status);
                    void'(expected_results.pop_front());
                end
            end
        end
    end

    // archive builder
    logic [7:0] arc[$];

    task automatic put16(logic [15:0] v);
        arc.insert(arc.size(), v[7:0]); arc.insert(arc.size(), v[15:8]);
    endtask

    task automatic put32(logic [31:0] v);
        put16(v[15:0]); put16(v[31:16]);
    endtask

    // defect: 0 none, 1 bad CRC, 2 bad flags, 3 method, 4 size mismatch,
    // 5 bad signature, 6 bad end record
    task automatic build_archive(int n_entries, int defect, int max_data, int max_name,
                                 int max_extra);
        logic [31:0] crc, cdir;
        int          nlen, xlen, dlen;
        logic [7:0]  payload[$];
        arc.delete();
        for (int e = 0; e < n_entries; e++) begin
            nlen = $urandom_range(1, max_name);
            xlen = ($urandom_range(0, 2) == 0) ? $urandom_range(1, max_extra) : 0;
            dlen = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, max_data);
            payload.delete();
            crc = 32'hFFFFFFFF;
            for (int i = 0; i < dlen; i++) begin
                payload.insert(payload.size(), 8'($urandom_range(0, 255)));
                crc = crc_step(crc, payload[i]);
            end
            crc = ~crc;
            if (defect == 1 && e == n_entries - 1) crc ^= 32'h1 << $urandom_range(0, 31);
            if (defect == 5 && e == n_entries - 1) put32(32'h04034B51);
            else put32(SIG_LOCAL);
            put16(20);
            if (defect == 2 && e == n_entries - 1) put16(16'h0001 << $urandom_range(0, 15));
            else put16($urandom_range(0, 1) ? FLAG_UTF8 : 16'h0000);
            put16((defect == 3 && e == n_entries - 1) ? 16'd8 : 16'd0);
            put32($urandom);
            put32(crc);
            put32((defect == 4 && e == n_entries - 1) ? dlen + 1 : dlen);
            put32(dlen);
            put16(nlen);
            put16(xlen);
            for (int i = 0; i < nlen + xlen; i++)
                arc.insert(arc.size(), 8'($urandom_range(0, 255)));
            foreach (payload[i]) arc.insert(arc.size(), payload[i]);
        end
        cdir = arc.size();
        put32(SIG_CDIR);
        for (int i = 0; i < $urandom_range(0, 30); i++)
            arc.insert(arc.size(), 8'($urandom_range(0, 255)));
        put32(SIG_END);
        put16(0); put16(0);
        put16(n_entries); put16((defect == 6) ? n_entries + 1 : n_entries);
        put32(arc.size() - 12 - cdir);
        put32(cdir);
        put16(0);
    endtask

    task automatic queue_archive(bit finish);
        pending_requests.insert(pending_requests.size(),
                                '{mode: MODE_START, data: $urandom_range(0, 255)});
        foreach (arc[i])
            pending_requests.insert(pending_requests.size(), '{mode: MODE_BYTE, data: arc[i]});
        if (finish)
            pending_requests.insert(pending_requests.size(),
                                    '{mode: MODE_FINISH, data: $urandom_range(0, 255)});
    endtask

    task automatic drain();
        while (pending_requests.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_limits(logic [31:0] b, logic [15:0] en, logic [15:0] nm,
                              logic [15:0] ex);
        logic [31:0] vals[4];
        vals = '{b, {16'd0, en}, {16'd0, nm}, {16'd0, ex}};
        for (int i = 0; i < 4; i++) begin
            @(negedge aclk);
            cfg_we <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_data <= vals[i];
        end
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        lim_bytes = b; lim_entries = en; lim_name = nm; lim_extra = ex;
    endtask

    initial begin
        int sent;
        lim_bytes = MAX_ENTRY_BYTES_RST; lim_entries = MAX_ENTRIES_RST;
        lim_name = NAME_LIMIT_RST; lim_extra = EXTRA_LIMIT_RST;
        clear_parser(PH_FAIL);
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: failed-after-reset behavior, odd modes, an empty archive, every defect variant
        pending_requests.insert(pending_requests.size(), '{mode: MODE_BYTE, data: 8'hFF});
        pending_requests.insert(pending_requests.size(), '{mode: MODE_FINISH, data: 8'h00});
        pending_requests.insert(pending_requests.size(), '{mode: MODE_NOP, data: 8'hA5});
        pending_requests.insert(pending_requests.size(), '{mode: MODE_START, data: 8'h5A});
        pending_requests.insert(pending_requests.size(), '{mode: MODE_NOP, data: 8'h00});
        pending_requests.insert(pending_requests.size(), '{mode: MODE_FINISH, data: 8'hFF});
        build_archive(0, 0, 1, 1, 1); queue_archive(1);
        pending_requests.insert(pending_requests.size(), '{mode: MODE_BYTE, data: 8'h00});
        pending_requests.insert(pending_requests.size(), '{mode: MODE_FINISH, data: 8'h00});
        build_archive(2, 0, 3, 2, 2); queue_archive(1);
        for (int d = 1; d <= 6; d++) begin
            build_archive(1, d, 4, 3, 2); queue_archive(1);
        end
        drain();

        // tight limits: names, extras, entry count, zero-byte entries
        set_limits(32'd0, 16'd0, 16'd1, 16'd0);
        build_archive(1, 0, 1, 1, 1); queue_archive(1);
        drain();
        set_limits(32'd3, 16'd2, 16'd3, 16'd1);
        for (int k = 0; k < 30; k++) begin
            build_archive($urandom_range(0, 3), ($urandom_range(0, 3) == 0) ? 
                          $urandom_range(1, 6) : 0, 4, 3, 2);
            queue_archive($urandom_range(0, 5) != 0);
        end
        drain();

        // wide limits, random bulk with pause once
        set_limits(32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        sent = 0;
        while (sent < 700) begin
            build_archive($urandom_range(0, 4), ($urandom_range(0, 4) == 0) ?
                          $urandom_range(1, 6) : 0, 20, 6, 4);
            queue_archive($urandom_range(0, 7) != 0);
            sent += arc.size();
            if ($urandom_range(0, 9) == 0)
                for (int i = 0; i < 10; i++)
                    pending_requests.insert(pending_requests.size(),
                                            '{mode: $urandom_range(0, 3),
                                              data: $urandom_range(0, 255)});
        end
        hold_off = 1'b1;
        while (expected_results.size() != 0 || s_valid)
            @(posedge aclk);
        hold_off = 1'b0;
        drain();

        set_limits(32'd10, 16'd3, 16'd5, 16'd3);
        sent = 0;
        while (sent < 700) begin
            build_archive($urandom_range(0, 4), ($urandom_range(0, 5) == 0) ?
                          $urandom_range(1, 6) : 0, 12, 6, 4);
            queue_archive($urandom_range(0, 7) != 0);
            sent += arc.size();
        end
        drain();
        repeat (10) @(posedge aclk);
        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// File: filelist.f
+incdir+design
design/zsc_pkg.sv
design/zsc_core.sv
design/zip_stored_stream_checker.sv
bench/testbench.sv
